// File: rtl/core/lis_pkg.sv
`default_nettype none

package lis_pkg;

    // Tail store capacity
    localparam int MAX_LEN = 4096;
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    // Length counter must hold MAX_LEN itself
    localparam int LEN_W   = $clog2(MAX_LEN + 1);

    // Port widths
    localparam int VALUE_W = 64;
    localparam int RUN_W   = 13;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [LEN_W-1:0]          len_t;
    typedef logic [ADDR_W-1:0]         addr_t;

endpackage : lis_pkg

`default_nettype wire

// File: rtl/core/longest_increasing_subsequence_length.sv
// Longest strictly increasing subsequence length, patience method.
//
// Input channel (s_valid/s_ready): one signed 64-bit value per request,
// with s_first starting a new sequence (length and overflow cleared first)
// and s_last marking its final element. Output channel (m_valid/m_ready):
// one result per request carrying the length after that value, an echo of
// s_last in m_final_res, and the sticky m_overflow flag.
//
// Each request binary-searches the tail memory for the first tail not
// less than the value, with one synchronous read per search step. The
// single-port read loop through the tail memory paces the requests: a new
// request is taken only in the idle state, after the last is written back.
// The result sits in an output register: the next request is accepted
// while it waits, and only the final write-back stalls while an older
// result is still held by the receiver.
//
// Reset clears the length, the overflow flag and the handshake state. The
// tail memory is not cleared: the search reads only entries below the
// current length, all of which have been written.
`default_nettype none

module longest_increasing_subsequence_length
    import lis_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,

    input  wire logic                     s_valid,
    output      logic                     s_ready,
    input  wire logic signed [VALUE_W-1:0] s_value,
    input  wire logic                     s_first,
    input  wire logic                     s_last,

    output      logic                     m_valid,
    input  wire logic                     m_ready,
    output      logic [RUN_W-1:0]         m_run_length,
    output      logic                     m_final_res,
    output      logic                     m_overflow
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // Tail memory: ascending smallest tails, one per run length
    value_t tail_mem [MAX_LEN];
    value_t rd_data_reg;
    logic   rd_en;
    addr_t  rd_addr;
    logic   wr_en;
    addr_t  wr_addr;

    logic [1:0] state_reg, state_next;
    len_t       len_reg, len_next;
    logic       ovf_reg, ovf_next;
    len_t       lo_reg, lo_next;
    len_t       hi_reg, hi_next;
    len_t       mid_reg, mid_next;
    value_t     key_reg;
    logic       last_reg;

    logic             m_valid_reg;
    logic [RUN_W-1:0] m_run_length_reg;
    logic             m_final_res_reg;
    logic             m_overflow_reg;

    // Search step helpers
    len_t   start_len;
    logic   tail_less;
    len_t   step_lo, step_hi;
    logic   out_free;
    logic   result_load;
    logic   [RUN_W+LEN_W-1:0] run_wide;

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    assign start_len = s_first ? '0 : len_reg;
    assign tail_less = (rd_data_reg < key_reg);
    assign step_lo   = tail_less ? len_t'(mid_reg + len_t'(1)) : lo_reg;
    assign step_hi   = tail_less ? hi_reg : mid_reg;

    always_comb begin
        state_next  = state_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        rd_en       = 1'b0;
        rd_addr     = mid_reg[ADDR_W-1:0];
        wr_en       = 1'b0;
        wr_addr     = lo_reg[ADDR_W-1:0];
        result_load = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    // Clear the sequence state on first, then open the search window
                    len_next = start_len;
                    ovf_next = s_first ? 1'b0 : ovf_reg;
                    lo_next  = '0;
                    hi_next  = start_len;
                    mid_next = start_len >> 1;
                    if (start_len != '0) begin
                        rd_en      = 1'b1;
                        rd_addr    = mid_next[ADDR_W-1:0];
                        state_next = ST_SEARCH;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SEARCH: begin
                // Narrow the window on the tail just read, issue the next probe
                lo_next  = step_lo;
                hi_next  = step_hi;
                mid_next = step_lo + ((step_hi - step_lo) >> 1);
                if (step_lo < step_hi) begin
                    rd_en   = 1'b1;
                    rd_addr = mid_next[ADDR_W-1:0];
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // Hold until the output register is free, then write back
                if (out_free) begin
                    result_load = 1'b1;
                    state_next  = ST_IDLE;
                    if (lo_reg >= len_t'(MAX_LEN)) begin
                        ovf_next = 1'b1;
                    end else begin
                        wr_en = 1'b1;
                        if (lo_reg == len_reg) begin
                            len_next = len_t'(len_reg + len_t'(1));
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Tail memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tail_mem[wr_addr] <= key_reg;
        end
        if (rd_en) begin
            rd_data_reg <= tail_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            if (result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Search window and request payload
    always_ff @(posedge aclk) begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        if (s_valid && s_ready) begin
            key_reg  <= s_value;
            last_reg <= s_last;
        end
    end

    // Report the length modulo the port width
    assign run_wide = {{RUN_W{1'b0}}, len_next};

    always_ff @(posedge aclk) begin
        if (result_load) begin
            m_run_length_reg <= run_wide[RUN_W-1:0];
            m_final_res_reg  <= last_reg;
            m_overflow_reg   <= ovf_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_run_length = m_run_length_reg;
    assign m_final_res  = m_final_res_reg;
    assign m_overflow   = m_overflow_reg;

endmodule : longest_increasing_subsequence_length

`default_nettype wire

// File: tb/sv/longest_increasing_subsequence_length_tb.sv
`timescale 1ns / 100ps

module longest_increasing_subsequence_length_tb
    import lis_pkg::*;
();

    // Clock half-period and run bounds
    localparam int CLK_HALF    = 6;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT = 1_000_000;
    // Time to let pass after the last result, well past a full search
    localparam int DRAIN_CYCLES = 40;
    // Long receiver hold-off that backs up the block and stalls its input
    localparam int LONG_HOLD   = 400;
    // Random requests per idling phase
    localparam int PHASE_ITEMS = 400;

    localparam value_t VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam value_t VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    // Shapes of the random sequences
    typedef enum int {
        SEQ_SCATTER,
        SEQ_CLUSTER,
        SEQ_CLIMB,
        SEQ_DESCEND
    } seq_kind_e;

    typedef struct packed {
        logic [RUN_W-1:0] run_length;
        logic             final_res;
        logic             overflow;
    } lis_result_t;

    // Tracks the tail store and length of the current sequence and keeps
    // the results still owed by the block, oldest first.
    class lis_length_tracker;
        value_t      tails[MAX_LEN];
        int          length;
        bit          overflow_seen;
        lis_result_t owed_results[$];
        int          errors;

        function new();
            length        = 0;
            overflow_seen = 0;
            errors        = 0;
        endfunction

        function int run_len();
            return length;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Apply one accepted request to the tail store and owe its result.
        function void note_request(value_t value, bit first, bit last);
            int          lo;
            int          hi;
            int          mid;
            lis_result_t r;
            if (first) begin
                length        = 0;
                overflow_seen = 0;
            end
            // Search for the first tail not less than the value
            lo = 0;
            hi = length;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (tails[mid] < value) lo = mid + 1;
                else hi = mid;
            end
            if (lo >= MAX_LEN) begin
                // Would extend past capacity: write nothing, hold length
                overflow_seen = 1;
            end else begin
                tails[lo] = value;
                if (lo == length) length++;
            end
            r.run_length = RUN_W'(length);
            r.final_res  = last;
            r.overflow   = overflow_seen;
            owed_results.push_back(r);
        endfunction

        function void check_result(logic [RUN_W-1:0] run_length, logic final_res,
                                   logic overflow);
            lis_result_t e;
            if (owed_results.size() == 0) begin
                $error("result with nothing owed: run_length %0d final_res %0b overflow %0b",
                       run_length, final_res, overflow);
                errors++;
                return;
            end
            e = owed_results.pop_front();
            if (run_length !== e.run_length) begin
                $error("run_length: expected %0d, got %0d", e.run_length, run_length);
                errors++;
            end
            if (final_res !== e.final_res) begin
                $error("final_res: expected %0b, got %0b", e.final_res, final_res);
                errors++;
            end
            if (overflow !== e.overflow) begin
                $error("overflow: expected %0b, got %0b", e.overflow, overflow);
                errors++;
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    value_t           s_value = '0;
    logic             s_first = 1'b0;
    logic             s_last  = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [RUN_W-1:0] m_run_length;
    logic             m_final_res;
    logic             m_overflow;

    lis_length_tracker tracker = new();

    // Idling knobs, in percent, set per phase
    int src_idle_pct  = 0;
    int rx_stall_pct  = 0;
    // Long hold-off asked of the receiver, taken over by its own process
    int rx_hold_ask   = 0;
    int requests_sent = 0;
    int cycle_count   = 0;

    longest_increasing_subsequence_length DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .s_first      (s_first),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_run_length (m_run_length),
        .m_final_res  (m_final_res),
        .m_overflow   (m_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Watchdog: end the run if the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: check each result taken at the edge, then pick m_ready
    // for the next edge. Signals read here are their values before the edge.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                tracker.check_result(m_run_length, m_final_res, m_overflow);
            if (rx_hold_ask > 0) begin
                hold_left   = rx_hold_ask;
                rx_hold_ask = 0;
            end
            if (hold_left > 0) begin
                // Count down the long hold-off with ready low
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    function automatic value_t any_value();
        return {$urandom, $urandom};
    endfunction

    // Offer one request and hold it until accepted. Valid stays high on
    // return so a request that follows at once goes out back to back; drop
    // it only when idling or pausing.
    task automatic send_item(value_t value, bit first, bit last);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_value <= value;
        s_first <= first;
        s_last  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_request(value, first, last);
        requests_sent++;
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic pause_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    // Extremes, equal values, strict increase and first/last combinations.
    task automatic send_directed();
        // Sequence without a first flag right after reset
        send_item('0, 1'b0, 1'b0);
        send_item(VALUE_MIN, 1'b1, 1'b0);
        send_item(VALUE_MAX, 1'b0, 1'b0);
        // Equal value replaces, no growth
        send_item(VALUE_MAX, 1'b0, 1'b0);
        send_item(VALUE_MIN, 1'b0, 1'b0);
        send_item(-1, 1'b0, 1'b0);
        send_item('0, 1'b0, 1'b0);
        send_item('0, 1'b0, 1'b0);
        send_item(1, 1'b0, 1'b1);
        // One-element sequence, first and last together
        send_item(5, 1'b1, 1'b1);
        // Alternating bit patterns, both signs
        send_item(64'h5555_5555_5555_5555, 1'b1, 1'b0);
        send_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
        send_item(64'h7FFF_FFFF_FFFF_FFFE, 1'b0, 1'b0);
        // Falling tail keeps the length
        send_item(VALUE_MAX, 1'b0, 1'b0);
        send_item(100, 1'b0, 1'b0);
        send_item(-100, 1'b0, 1'b0);
        send_item(VALUE_MIN, 1'b0, 1'b1);
        // Last repeated after the sequence ended
        send_item(VALUE_MIN, 1'b0, 1'b1);
    endtask

    // Climb to full capacity, then try to extend past it.
    task automatic fill_to_capacity();
        value_t v;
        v = VALUE_MIN;
        // Back up the block while the climb starts
        rx_hold_ask = LONG_HOLD;
        send_item(v, 1'b1, 1'b0);
        while (tracker.run_len() < MAX_LEN) begin
            if ($urandom_range(49) == 0) begin
                send_item(v, 1'b0, 1'b0);
            end else begin
                v = v + $urandom_range(1, 1 << 20);
                send_item(v, 1'b0, 1'b0);
            end
        end
        // Past capacity: saturate and raise the sticky flag
        send_item(v + 1, 1'b0, 1'b0);
        send_item(v, 1'b0, 1'b0);
        send_item(VALUE_MIN, 1'b0, 1'b0);
        send_item(VALUE_MAX, 1'b0, 1'b0);
        send_item(VALUE_MAX, 1'b0, 1'b1);
        // A new sequence clears the flag
        send_item('0, 1'b1, 1'b1);
    endtask

    // Well-formed sequences of random shape and content, with some broken
    // framing and stray flags mixed in.
    task automatic send_random(int quota);
        int        target;
        int        n;
        int        k;
        bit        broken;
        bit        first;
        bit        last;
        seq_kind_e kind;
        value_t    v;
        target = requests_sent + quota;
        while (requests_sent < target) begin
            kind   = seq_kind_e'($urandom_range(0, 3));
            n      = ($urandom_range(9) == 0) ? $urandom_range(31, 300)
                                              : $urandom_range(1, 30);
            broken = ($urandom_range(99) < 15);
            v      = any_value() >>> 4;
            for (k = 0; k < n; k++) begin
                case (kind)
                    SEQ_SCATTER: begin
                        case ($urandom_range(9))
                            0: v = VALUE_MIN;
                            1: v = VALUE_MAX;
                            default: v = any_value();
                        endcase
                    end
                    SEQ_CLUSTER: begin
                        v = value_t'(int'($urandom_range(0, 16)) - 8);
                    end
                    SEQ_CLIMB: begin
                        // Mostly rising, some equal steps and drops
                        if ($urandom_range(9) == 0) v = v - $urandom_range(0, 64);
                        else v = v + $urandom_range(0, 3);
                    end
                    default: begin
                        v = v - $urandom_range(0, 5);
                    end
                endcase
                first = (k == 0);
                last  = (k == n - 1);
                if (broken) begin
                    first = first ? bit'($urandom_range(1)) : ($urandom_range(29) == 0);
                    last  = last ? bit'($urandom_range(1)) : ($urandom_range(29) == 0);
                end
                send_item(v, first, last);
            end
        end
    endtask

    task automatic run_phase(int idle_pct, int stall_pct);
        src_idle_pct = idle_pct;
        rx_stall_pct = stall_pct;
        send_random(PHASE_ITEMS);
        pause_until_drained();
    endtask

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // No idling: directed requests, then the capacity climb
        send_directed();
        pause_until_drained();
        fill_to_capacity();
        pause_until_drained();

        run_phase(0, 0);
        run_phase(83, 0);
        run_phase(0, 83);
        run_phase(8, 8);

        // Drain, then give any stray result time to show up
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/lis_pkg.sv
rtl/core/longest_increasing_subsequence_length.sv
tb/sv/longest_increasing_subsequence_length_tb.sv
